// ===== rtl/rdc_pkg.sv =====
// Shared types, constants and helpers of the radix digit converter.
package rdc_pkg;

  // Width of the value field as it travels on the input stream.
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned VALUE_BITS_MAX = 64;

  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned OUT_W     = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;

  // Quotient bits resolved by the divider in one cycle.
  localparam int unsigned STEP_BITS = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOWER  = 7'd87;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_UPPER  = 7'd29;  // 'A' - 36
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_LOW_END = 6'd36;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } rdc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DIGIT_TEN) begin
      return d_ext + CHAR_ZERO;
    end else if (d < DIGIT_LOW_END) begin
      return d_ext + CHAR_LOWER;
    end else begin
      return d_ext + CHAR_UPPER;
    end
  endfunction

endpackage

// ===== rtl/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rdc_divider.sv =====
// Iterative divider of a value by a narrow radix, several quotient bits per cycle.
module rdc_divider
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output div_stat_t             stat_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [DIGIT_W-1:0]    remainder_o
);

  localparam int unsigned DIV_W = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned STEPS = DIV_W / STEP_BITS;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DIV_W-1:0]   quot_q, quot_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] div_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [DIV_W-1:0]   step_q_val;
  logic [DIGIT_W:0]   step_r_val;

  // Shift-and-subtract over STEP_BITS dividend bits; the remainder stays below the divisor.
  always_comb begin
    logic [DIV_W-1:0] q;
    logic [DIGIT_W:0] r;
    q = quot_q;
    r = {1'b0, rem_q};
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[DIGIT_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r    = r - {1'b0, div_q};
        q[0] = 1'b1;
      end
    end
    step_q_val = q;
    step_r_val = r;
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      quot_d = DIV_W'(dividend_i);
      rem_d  = '0;
      cnt_d  = CNT_W'(STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = step_q_val;
      rem_d  = step_r_val[DIGIT_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i && !busy_q) begin
      div_q <= divisor_i;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quot_q[VALUE_BITS-1:0];
  assign remainder_o  = rem_q;

endmodule

// ===== rtl/radix_digit_converter.sv =====
// Radix digit converter: streams the digits of an unsigned value in a configured base.
//
// Each input item is one unsigned value; the block answers with one output item per digit in
// the base held in the radix register (2 to 62, reset 10; 0 and 1 act as 2, 63 acts as 62),
// most significant digit first, as an ASCII character with tlast on the units digit. Zero
// gives the single digit '0'. Digits are found by repeated division in one shared divider that
// resolves four quotient bits per cycle; the divider's done strobe both stores the digit and
// starts the next division. The digits are kept in a small digit RAM and then read back in
// reverse, each emitted digit passing through a RAM read state and then a show state that
// waits for the sink. One item is in flight at a time; s_axis_tready is high only while the
// block is idle. Write the radix only while idle.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [VALUE_W-1:0] s_axis_tdata_i,  // [31:0] value
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OUT_W-1:0]   m_axis_tdata_o,  // [6:0] digit_char, [7] zero fill
  output logic               m_axis_tlast_o,  // last_digit
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(VALUE_BITS);

  rdc_state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_eff;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  quot_zero;

  logic                  ram_we;
  logic                  ram_re;
  logic [DIGIT_W-1:0]    ram_rdata;

  logic [VALUE_BITS_MAX-1:0] value_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  assign value_ext = {{(VALUE_BITS_MAX - VALUE_W){1'b0}}, s_axis_tdata_i};
  assign quot_zero = (div_quot == '0);

  // The first division takes the input value, later ones the previous quotient.
  assign div_dividend = (state_q == ST_IDLE) ? value_ext[VALUE_BITS-1:0] : div_quot;

  rdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_eff),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d  = state_q;
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d  = ST_DIV;
          wr_idx_d = '0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (quot_zero) begin
            state_d  = ST_READ;
            rd_idx_d = wr_idx_q;
          end else begin
            wr_idx_d = wr_idx_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (m_axis_tready_i) begin
          if (rd_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d  = ST_READ;
            rd_idx_d = rd_idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    div_start       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        div_start       = s_axis_tvalid_i;
      end
      ST_DIV: begin
        ram_we    = div_stat.done;
        div_start = div_stat.done && !quot_zero;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_SHOW: begin
        m_axis_tvalid_o = 1'b1;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata_o = {1'b0, digit_to_char(ram_rdata)};
  assign m_axis_tlast_o = (rd_idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output sides active together");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division phase");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("block not idle after the last digit item");

  a_final_digit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_stat.done && quot_zero) |=> (state_q == ST_READ && !div_stat.busy))
    else $error("digit readout did not follow the final division");

endmodule

// ===== verif/rdc_checker.sv =====
// Checker that watches the converter's streams, predicts each digit string and compares results.
module rdc_checker
  import rdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [VALUE_W-1:0] s_tdata_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [OUT_W-1:0]   m_tdata_i,
  input  logic               m_tlast_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [RADIX_W-1:0] cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam logic [7:0] ASCII_DIGIT = "0";
  localparam logic [7:0] ASCII_LOWER = "a";
  localparam logic [7:0] ASCII_UPPER = "A";

  typedef struct packed {
    logic [OUT_W-1:0] data;
    logic             last;
  } digit_t;

  digit_t             digit_q[$];
  digit_t             want;
  logic [RADIX_W-1:0] radix_q;
  int unsigned        fails = 0;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d8 < 8'd10) begin
      return CHAR_W'(ASCII_DIGIT + d8);
    end else if (d8 < 8'd36) begin
      return CHAR_W'(ASCII_LOWER + d8 - 8'd10);
    end else begin
      return CHAR_W'(ASCII_UPPER + d8 - 8'd36);
    end
  endfunction

  // Splits the value into digits by repeated division, then queues them most significant first.
  task automatic queue_digits(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] digs [VALUE_W];
    logic [VALUE_W-1:0] rest;
    int                 n;
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
    rest = value;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(rest % VALUE_W'(base));
      rest    = rest / VALUE_W'(base);
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      digit_q.push_back(digit_t'{data: {1'b0, ascii_of(digs[k])}, last: (k == 0)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      digit_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (digit_q.size() == 0) begin
          fails++;
          $display("%0t: output item with no digit pending: expected none, got data=%h last=%b",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          want = digit_q.pop_front();
          if (m_tdata_i !== want.data) begin
            fails++;
            $display("%0t: digit char mismatch: expected %h, got %h", $time, want.data,
                     m_tdata_i);
          end
          if (m_tlast_i !== want.last) begin
            fails++;
            $display("%0t: last-digit flag mismatch: expected %b, got %b", $time, want.last,
                     m_tlast_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        radix_q = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        queue_digits(s_tdata_i, radix_q);
      end
      pending_o    <= digit_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives values and radix writes into the converter and reports the verdict.
module tb_top;
  import rdc_pkg::*;

  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned WATCHDOG     = 5000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 32;
  localparam logic [RADIX_W-1:0] PHASE_RADIX [PHASES-1] =
    '{6'd2, 6'd62, 6'd36, 6'd37, 6'd16, 6'd63, 6'd1};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;
  int unsigned        fail_count;
  int unsigned        pending;

  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_done_cnt = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  radix_digit_converter u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [31:0] value
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [6:0] digit_char, [7] zero fill
    .m_axis_tlast_o  (m_tlast),   // last_digit
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  rdc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Digit sink: random back-pressure unless sink_idle_on is clear, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_done_cnt) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done_cnt++;
      end else begin
        m_tready <= !sink_idle_on || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (src_idle_on && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_list(input logic [VALUE_W-1:0] vals[$]);
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Waits until every expected digit has come out, then lets the block settle.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    s_tvalid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-width values, values of random length and small values near digit boundaries.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return ($urandom() | 32'h8000_0000) >> $urandom_range(0, 31);
      2: return $urandom_range(0, 70);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset radix first, then the base extremes, the clamped settings and bases 36 and 37.
    send_list('{32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'h8000_0000});
    set_radix(6'd2);
    send_list('{32'd0, 32'd1, 32'hFFFF_FFFF, 32'hAAAA_AAAA});
    set_radix(6'd62);
    send_list('{32'd61, 32'd62, 32'd35, 32'd36, 32'd3843, 32'hFFFF_FFFF});
    set_radix(6'd0);
    send_value(32'd5);
    set_radix(6'd1);
    send_value(32'd6);
    set_radix(6'd63);
    send_list('{32'd61, 32'd62, 32'd3844});
    set_radix(6'd36);
    send_list('{32'd35, 32'd36});
    set_radix(6'd37);
    send_value(32'd36);

    for (int p = 0; p < PHASES; p++) begin
      r = (p == PHASES - 1) ? RADIX_W'($urandom_range(0, 63)) : PHASE_RADIX[p];
      set_radix(r);
      src_idle_on  = (p != 4);
      sink_idle_on = (p != 4);
      if (p == 3) begin
        hold_req_cnt++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(pick_value());
      end
    end

    s_tvalid <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
